### design/pwg_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic waveform generator: mode and register codes,
// fixed field widths. No dependencies.
package pwg_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PERIOD_W = 31;
  localparam int unsigned DELAY_W  = 64;
  localparam int unsigned SLOPE_W  = 17;
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 3'd0,
    MODE_SQUARE   = 3'd1,
    MODE_TRIANGLE = 3'd2,
    MODE_RAMP     = 3'd3,
    MODE_SAWTOOTH = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_PERIOD    = 2'd1,
    CFG_AMPLITUDE = 2'd2,
    CFG_OFFSET    = 2'd3
  } cfg_idx_e;

endpackage

### design/periodic_waveform_generator.sv
`timescale 1ns / 1ps
// Periodic waveform generator top level: configuration registers, phase
// divider (pwg_phase_div), waveform multiply and output register. Uses pwg_pkg.
//
// Takes one time sample per cycle unless the output stalls and returns one
// delay/slope result per sample, in order. The phase divider resolves one
// quotient bit per pipeline stage: TIME_BITS + 1 stages for the floor-mod and
// PHASE_FRAC_BITS stages for the phase fraction. A stalled output holds the
// whole pipeline. A period of zero acts as one. Write configuration only
// while no samples are in flight.
module periodic_waveform_generator #(
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned PHASE_FRAC_BITS = 16,
  parameter int unsigned AMP_BITS        = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // sample_time
  input  logic [((TIME_BITS+7)/8)*8-1:0]            s_axis_tdata,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // delay_value, slope_value
  output logic [((pwg_pkg::DELAY_W+pwg_pkg::SLOPE_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [pwg_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [((TIME_BITS > 32) ? TIME_BITS : 32)-1:0] cfg_data_i
);
  import pwg_pkg::*;

  localparam int unsigned TW   = TIME_BITS;
  localparam int unsigned DW   = TIME_BITS + 1;
  localparam int unsigned F    = PHASE_FRAC_BITS;
  localparam int unsigned AW   = AMP_BITS;
  localparam int unsigned PAW  = AW + F + 1;
  localparam int unsigned PRW  = DW + AW;
  localparam int unsigned PXW  = (PRW > 49) ? PRW : 49;
  localparam int unsigned SWW  = AW + 2;
  localparam int unsigned OUTW = ((DELAY_W + SLOPE_W + 7) / 8) * 8;

  localparam logic signed [PXW-1:0] RAMP_MAX = PXW'(64'sd140737488355327);
  localparam logic signed [PXW-1:0] RAMP_MIN = -RAMP_MAX - PXW'(1);

  mode_e                    mode_q;
  logic [PERIOD_W-1:0]      period_q;
  logic signed [AW-1:0]     amp_q;
  logic signed [TW-1:0]     offset_q;

  logic                     en;
  logic [PERIOD_W-1:0]      period_eff;
  logic signed [TW-1:0]     sample_time;
  logic signed [DW-1:0]     diff;

  logic                     dv_valid;
  logic signed [DW-1:0]     dv_diff;
  logic [F-1:0]             dv_frac;

  logic signed [F+1:0]      dev;
  logic signed [F+1:0]      dev_abs;
  logic signed [F+1:0]      mul_w;
  logic signed [F:0]        mul_b;
  logic signed [SWW-1:0]    slope_w;
  logic signed [63:0]       slope_x;

  logic                     mul_vld_q;
  logic signed [PAW-1:0]    pa_q;
  logic signed [PRW-1:0]    pr_q;
  logic                     ge_half_q;
  logic [SLOPE_W-1:0]       slope_q;

  logic signed [DELAY_W-1:0] wave_q16;
  logic signed [DELAY_W-1:0] square_d;
  logic signed [DELAY_W-1:0] ramp_d;
  logic signed [PXW-1:0]     prx;
  logic signed [DELAY_W-1:0] delay_d;

  logic                      out_vld_q;
  logic [DELAY_W-1:0]        out_delay_q;
  logic [SLOPE_W-1:0]        out_slope_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      period_q <= PERIOD_W'(1);
      amp_q    <= '0;
      offset_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:      mode_q   <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_PERIOD:    period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_AMPLITUDE: amp_q    <= cfg_data_i[AW-1:0];
        CFG_OFFSET:    offset_q <= cfg_data_i[TW-1:0];
        default:       mode_q   <= mode_q;
      endcase
    end
  end

  // input and phase pipeline
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign period_eff    = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign sample_time   = s_axis_tdata[TW-1:0];
  assign diff          = DW'(sample_time) - DW'(offset_q);

  pwg_phase_div #(
    .TIME_BITS       (TIME_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_phase_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .diff_i   (diff),
    .period_i (period_eff),
    .valid_o  (dv_valid),
    .diff_o   (dv_diff),
    .frac_o   (dv_frac)
  );

  // multiply stage
  assign dev     = $signed({2'b00, dv_frac}) - $signed((F+2)'(1) << (F - 1));
  assign dev_abs = dev[F+1] ? -dev : dev;
  assign mul_w   = (mode_q == MODE_TRIANGLE) ?
                   (dev_abs <<< 1) - $signed((F+2)'(1) << (F - 1)) : dev;
  assign mul_b   = mul_w[F:0];

  always_comb begin
    unique case (mode_q)
      MODE_TRIANGLE: slope_w = dv_frac[F-1] ? SWW'(amp_q) <<< 1 : -(SWW'(amp_q) <<< 1);
      MODE_RAMP,
      MODE_SAWTOOTH: slope_w = SWW'(amp_q);
      default:       slope_w = '0;
    endcase
  end

  assign slope_x = 64'(slope_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q      <= PAW'(amp_q) * PAW'(mul_b);
      pr_q      <= PRW'(dv_diff) * PRW'(amp_q);
      ge_half_q <= dv_frac[F-1];
      slope_q   <= slope_x[SLOPE_W-1:0];
    end
  end

  // scale to Q.16, saturate ramp, select
  if (F >= OUT_FRAC) begin : g_q16_down
    logic signed [PAW-1:0] pa_sh;
    assign pa_sh    = pa_q >>> (F - OUT_FRAC);
    assign wave_q16 = DELAY_W'(pa_sh);
  end else begin : g_q16_up
    assign wave_q16 = DELAY_W'(pa_q) <<< (OUT_FRAC - F);
  end

  assign square_d = ge_half_q ? (DELAY_W'(amp_q) <<< (OUT_FRAC - 1))
                              : -(DELAY_W'(amp_q) <<< (OUT_FRAC - 1));
  assign prx      = PXW'(pr_q);

  always_comb begin
    if (prx > RAMP_MAX) begin
      ramp_d = {1'b0, {(DELAY_W-1){1'b1}}};
    end else if (prx < RAMP_MIN) begin
      ramp_d = {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      ramp_d = {prx[DELAY_W-OUT_FRAC-1:0], {OUT_FRAC{1'b0}}};
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_SQUARE:   delay_d = square_d;
      MODE_TRIANGLE,
      MODE_SAWTOOTH: delay_d = wave_q16;
      MODE_RAMP:     delay_d = ramp_d;
      default:       delay_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_delay_q <= delay_d;
      out_slope_q <= slope_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUTW'({out_slope_q, out_delay_q});

endmodule

### design/pwg_phase_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: floor-mod of the time difference by the period,
// then the phase fraction, one quotient bit per stage. Uses pwg_pkg.
module pwg_phase_div #(
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [TIME_BITS:0]           diff_i,
  input  logic [pwg_pkg::PERIOD_W-1:0]        period_i,
  output logic                                valid_o,
  output logic signed [TIME_BITS:0]           diff_o,
  output logic [PHASE_FRAC_BITS-1:0]          frac_o
);
  import pwg_pkg::*;

  localparam int unsigned DW = TIME_BITS + 1;
  localparam int unsigned MW = TIME_BITS + 1;
  localparam int unsigned RW = PERIOD_W + 1;
  localparam int unsigned F  = PHASE_FRAC_BITS;

  logic [MW:0]              dv_vld_q;
  logic [RW-1:0]            dv_rem_q  [MW+1];
  logic [MW-1:0]            dv_mag_q  [MW+1];
  logic signed [DW-1:0]     dv_diff_q [MW+1];

  logic [F:0]               fr_vld_q;
  logic [RW-1:0]            fr_rem_q  [F+1];
  logic [F-1:0]             fr_q      [F+1];
  logic signed [DW-1:0]     fr_diff_q [F+1];

  logic [RW-1:0]            per_ext;
  logic [RW-1:0]            fix_rem;

  assign per_ext = {1'b0, period_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_diff_q[0] <= diff_i;
      dv_rem_q[0]  <= '0;
      dv_mag_q[0]  <= diff_i[DW-1] ? MW'(-diff_i) : MW'(diff_i);
    end
  end

  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [RW-1:0] rem_sh;
    logic          ge;
    assign rem_sh = {dv_rem_q[k][RW-2:0], dv_mag_q[k][MW-1]};
    assign ge     = rem_sh >= per_ext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k+1]  <= ge ? rem_sh - per_ext : rem_sh;
        dv_mag_q[k+1]  <= dv_mag_q[k] << 1;
        dv_diff_q[k+1] <= dv_diff_q[k];
      end
    end
  end

  // fold a negative difference into the floor-mod range
  assign fix_rem = (dv_diff_q[MW][DW-1] && (dv_rem_q[MW] != '0)) ?
                   per_ext - dv_rem_q[MW] : dv_rem_q[MW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      fr_vld_q[0] <= dv_vld_q[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_rem_q[0]  <= fix_rem;
      fr_q[0]      <= '0;
      fr_diff_q[0] <= dv_diff_q[MW];
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_frac
    logic [RW-1:0] rem_sh;
    logic          ge;
    assign rem_sh = {fr_rem_q[j][RW-2:0], 1'b0};
    assign ge     = rem_sh >= per_ext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fr_vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        fr_vld_q[j+1] <= fr_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fr_rem_q[j+1]  <= ge ? rem_sh - per_ext : rem_sh;
        fr_q[j+1]      <= {fr_q[j][F-2:0], ge};
        fr_diff_q[j+1] <= fr_diff_q[j];
      end
    end
  end

  assign valid_o = fr_vld_q[F];
  assign diff_o  = fr_diff_q[F];
  assign frac_o  = fr_q[F];

endmodule
